>>> sv/cfr_pkg.sv
// Shared types, constants and register codes of the checksummed frame receiver.
package cfr_pkg;

    localparam int PAYLOAD_BYTES_DEF = 8;

    localparam int BYTE_W    = 8;
    localparam int SUM_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CODE_W    = 4;

    // Stream payload widths
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_FIRST  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_SECOND = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RECEIVE_ID    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TAIL_FIRST    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TAIL_SECOND   = 3'd4;

    // Register reset values
    localparam logic [BYTE_W-1:0] HEADER_FIRST_RST  = 8'hAA;
    localparam logic [BYTE_W-1:0] HEADER_SECOND_RST = 8'hBB;
    localparam logic [BYTE_W-1:0] RECEIVE_ID_RST    = 8'h00;
    localparam logic [BYTE_W-1:0] TAIL_FIRST_RST    = 8'hEE;
    localparam logic [BYTE_W-1:0] TAIL_SECOND_RST   = 8'hFF;

    // Function / subfunction codes
    localparam logic [BYTE_W-1:0] FUNC_DRIVE = 8'h01;
    localparam logic [BYTE_W-1:0] SUB_STATUS = 8'h00;
    localparam logic [BYTE_W-1:0] SUB_FAULT  = 8'h01;

    // Fault codes
    localparam logic [CODE_W-1:0] FAULT_NONE   = 4'd0;
    localparam logic [CODE_W-1:0] FAULT_L2_B0  = 4'd14;
    localparam logic [CODE_W-1:0] FAULT_L2_B1  = 4'd15;
    localparam int                FAULT_L1_BITS = 13;

    typedef enum logic [1:0] {
        KIND_STATUS = 2'd0,
        KIND_FAULT  = 2'd1,
        KIND_OTHER  = 2'd2
    } kind_t;

    typedef struct packed {
        logic [BYTE_W-1:0] header_first;
        logic [BYTE_W-1:0] header_second;
        logic [BYTE_W-1:0] receive_id;
        logic [BYTE_W-1:0] tail_first;
        logic [BYTE_W-1:0] tail_second;
    } cfg_t;

    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] func_code;
        logic [BYTE_W-1:0] sub_func;
        logic [15:0]       feedback_speed;
        logic [BYTE_W-1:0] lower_status;
        logic [CODE_W-1:0] fault_code;
    } result_t;

endpackage

>>> sv/cfr_fault_enc.sv
// Fault code priority encoder for fault frames.
module cfr_fault_enc (
    input  logic [15:0]                lv1,
    input  logic [cfr_pkg::BYTE_W-1:0] lv2,
    input  logic                       fault_latched,
    output logic [cfr_pkg::CODE_W-1:0] fault_code
);
    import cfr_pkg::*;

    logic [CODE_W-1:0] code;

    // lowest set level-one bit wins, then level-two bits
    always_comb begin
        code = FAULT_NONE;
        if (lv2[1]) begin
            code = FAULT_L2_B1;
        end
        if (lv2[0]) begin
            code = FAULT_L2_B0;
        end
        for (int k = FAULT_L1_BITS - 1; k >= 0; k--) begin
            if (lv1[k]) begin
                code = CODE_W'(k + 1);
            end
        end
    end

    assign fault_code = fault_latched ? FAULT_NONE : code;

endmodule

>>> sv/cfr_parser.sv
// Byte-serial frame parser: phase tracking, checksum, held fields and result build.
module cfr_parser #(
    parameter int PAYLOAD_BYTES = cfr_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       step,
    input  logic [cfr_pkg::BYTE_W-1:0] rx_byte,
    input  logic                       fault_latched,
    input  cfr_pkg::cfg_t              cfg,
    output logic                       frame_done,
    output cfr_pkg::result_t           result
);
    import cfr_pkg::*;

    localparam int CNT_W = $clog2(PAYLOAD_BYTES);

    typedef enum logic [3:0] {
        PH_HUNT  = 4'd0,
        PH_HDR2  = 4'd1,
        PH_ID    = 4'd2,
        PH_FUNC  = 4'd3,
        PH_SUB   = 4'd4,
        PH_DATA  = 4'd5,
        PH_SUMH  = 4'd6,
        PH_SUML  = 4'd7,
        PH_TAIL1 = 4'd8,
        PH_TAIL2 = 4'd9
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [CNT_W-1:0]   count_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [BYTE_W-1:0]  sum_hi_reg;
    logic [BYTE_W-1:0]  func_reg;
    logic [BYTE_W-1:0]  sub_reg;
    logic [15:0]        speed_reg;
    logic [BYTE_W-1:0]  status_reg;
    // only data0, data1 and data3 are ever read
    logic [BYTE_W-1:0]  data0_reg, data1_reg, data3_reg;

    logic [SUM_W-1:0]   sum_add;
    logic               is_status, is_fault;
    logic [CODE_W-1:0]  code;

    assign sum_add = sum_reg + SUM_W'(rx_byte);

    always_comb begin
        phase_next = PH_HUNT;
        unique case (phase_reg)
            PH_HUNT:  phase_next = (rx_byte == cfg.header_first) ? PH_HDR2 : PH_HUNT;
            PH_HDR2:  phase_next = (rx_byte == cfg.header_second) ? PH_ID : PH_HUNT;
            PH_ID:    phase_next = (rx_byte == cfg.receive_id) ? PH_FUNC : PH_HUNT;
            PH_FUNC:  phase_next = PH_SUB;
            PH_SUB:   phase_next = PH_DATA;
            PH_DATA:  phase_next = (count_reg == CNT_W'(PAYLOAD_BYTES - 1)) ? PH_SUMH
                                                                          : PH_DATA;
            PH_SUMH:  phase_next = PH_SUML;
            PH_SUML:  phase_next = ({sum_hi_reg, rx_byte} == sum_reg) ? PH_TAIL1 : PH_HUNT;
            PH_TAIL1: phase_next = (rx_byte == cfg.tail_first) ? PH_TAIL2 : PH_HUNT;
            PH_TAIL2: phase_next = PH_HUNT;
            default:  phase_next = PH_HUNT;
        endcase
    end

    assign frame_done = (phase_reg == PH_TAIL2) && (rx_byte == cfg.tail_second);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HUNT;
            count_reg  <= '0;
            sum_reg    <= '0;
            sum_hi_reg <= '0;
            func_reg   <= '0;
            sub_reg    <= '0;
            speed_reg  <= '0;
            status_reg <= '0;
        end else if (step) begin
            phase_reg <= phase_next;
            unique case (phase_reg)
                PH_ID:   sum_reg <= SUM_W'(rx_byte);
                PH_FUNC: begin
                    func_reg <= rx_byte;
                    sum_reg  <= sum_add;
                end
                PH_SUB: begin
                    sub_reg   <= rx_byte;
                    sum_reg   <= sum_add;
                    count_reg <= '0;
                end
                PH_DATA: begin
                    sum_reg   <= sum_add;
                    count_reg <= count_reg + CNT_W'(1);
                end
                PH_SUMH: sum_hi_reg <= rx_byte;
                PH_TAIL2: begin
                    if (frame_done && is_status) begin
                        speed_reg  <= {data0_reg, data1_reg};
                        status_reg <= data3_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    // payload bytes, no reset
    always_ff @(posedge aclk) begin
        if (step && phase_reg == PH_DATA) begin
            if (count_reg == CNT_W'(0)) data0_reg <= rx_byte;
            if (count_reg == CNT_W'(1)) data1_reg <= rx_byte;
            if (count_reg == CNT_W'(3)) data3_reg <= rx_byte;
        end
    end

    assign is_status = (func_reg == FUNC_DRIVE) && (sub_reg == SUB_STATUS);
    assign is_fault  = (func_reg == FUNC_DRIVE) && (sub_reg == SUB_FAULT);

    cfr_fault_enc u_fault_enc (
        .lv1           ({data0_reg, data1_reg}),
        .lv2           (data3_reg),
        .fault_latched (fault_latched),
        .fault_code    (code)
    );

    always_comb begin
        result.func_code = func_reg;
        result.sub_func  = sub_reg;
        if (is_status) begin
            result.kind           = KIND_STATUS;
            result.feedback_speed = {data0_reg, data1_reg};
            result.lower_status   = data3_reg;
            result.fault_code     = FAULT_NONE;
        end else begin
            result.kind           = is_fault ? KIND_FAULT : KIND_OTHER;
            result.feedback_speed = speed_reg;
            result.lower_status   = status_reg;
            result.fault_code     = is_fault ? code : FAULT_NONE;
        end
    end

endmodule

>>> sv/checksummed_frame_receiver_top.sv
// Top level of the checksummed frame receiver: stream ports, config registers, I/O stages.
//
//  channel   | direction | handshake         | contents
//  ----------+-----------+-------------------+------------------------------------------
//  s_*       | in        | s_tvalid/s_tready | one received byte + fault-latched flag
//  m_*       | out       | m_tvalid/m_tready | one result per valid frame, kind in tuser
//  cfg_*     | in        | cfg_we            | header, ID and tail bytes, no read-back
//
//  One byte per clock sustained, unless the output stall described below holds it. A
//  byte is held in the input register, parsed by short logic and, on the second tail
//  byte of a good frame, registered in the output register as the result.
//  Reset is synchronous, active low; parser goes back to the header hunt and config
//  registers take their defaults. A stalled output blocks the input only when the
//  byte in the input register completes a frame and the output register is full.
module checksummed_frame_receiver_top #(
    parameter int PAYLOAD_BYTES = cfr_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [cfr_pkg::S_TDATA_W-1:0] s_tdata,  // [7:0] rx_byte, [8] fault_latched
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [7:0] func_code, [15:8] sub_func, [31:16] feedback_speed,
    // [39:32] lower_status, [43:40] fault_code
    output logic [cfr_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [cfr_pkg::M_TUSER_W-1:0] m_tuser,  // [1:0] frame_kind
    // configuration writes
    input  logic                          cfg_we,
    input  logic [cfr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cfr_pkg::BYTE_W-1:0]    cfg_wdata
);
    import cfr_pkg::*;

    cfg_t              cfg_reg;

    // input register
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_latched_reg;

    // output register
    logic              out_valid_reg;
    result_t           out_res_reg;

    logic              frame_done;
    result_t           result;
    logic              out_free;
    logic              step;
    logic              s_xfer;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.header_first  <= HEADER_FIRST_RST;
            cfg_reg.header_second <= HEADER_SECOND_RST;
            cfg_reg.receive_id    <= RECEIVE_ID_RST;
            cfg_reg.tail_first    <= TAIL_FIRST_RST;
            cfg_reg.tail_second   <= TAIL_SECOND_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_HEADER_FIRST:  cfg_reg.header_first  <= cfg_wdata;
                REG_HEADER_SECOND: cfg_reg.header_second <= cfg_wdata;
                REG_RECEIVE_ID:    cfg_reg.receive_id    <= cfg_wdata;
                REG_TAIL_FIRST:    cfg_reg.tail_first    <= cfg_wdata;
                REG_TAIL_SECOND:   cfg_reg.tail_second   <= cfg_wdata;
                default: ;  // indexes past the list are dropped
            endcase
        end
    end

    // held byte advances unless it completes a frame while the result slot is busy
    assign out_free = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && (!frame_done || out_free);
    assign s_tready = !in_valid_reg || step;
    assign s_xfer   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_xfer) begin
            in_valid_reg <= 1'b1;
        end else if (step) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_byte_reg    <= s_tdata[BYTE_W-1:0];
            in_latched_reg <= s_tdata[BYTE_W];
        end
    end

    cfr_parser #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (step),
        .rx_byte       (in_byte_reg),
        .fault_latched (in_latched_reg),
        .cfg           (cfg_reg),
        .frame_done    (frame_done),
        .result        (result)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step && frame_done) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && frame_done) begin
            out_res_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.kind;
    assign m_tdata  = {4'b0000,
                       out_res_reg.fault_code,
                       out_res_reg.lower_status,
                       out_res_reg.feedback_speed,
                       out_res_reg.sub_func,
                       out_res_reg.func_code};

endmodule

>>> verif/checksummed_frame_receiver_checker.sv
// Checker for the checksummed frame receiver: mirrors the parser, predicts results, compares.
module checksummed_frame_receiver_checker #(
    parameter int PAYLOAD_BYTES = cfr_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [cfr_pkg::S_TDATA_W-1:0]  s_tdata,   // [7:0] rx_byte, [8] fault_latched
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    // [7:0] func_code, [15:8] sub_func, [31:16] feedback_speed,
    // [39:32] lower_status, [43:40] fault_code
    input  logic [cfr_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic [cfr_pkg::M_TUSER_W-1:0]  m_tuser,   // [1:0] frame_kind
    input  logic                           cfg_we,
    input  logic [cfr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cfr_pkg::BYTE_W-1:0]     cfg_wdata,
    output int                             mismatches,
    output int                             results_pending,
    output int                             results_checked
);
    timeunit 1ns;
    timeprecision 1ps;
    import cfr_pkg::*;

    typedef enum logic [3:0] {
        P_HUNT, P_HDR2, P_ID, P_FUNC, P_SUB, P_DATA, P_SUM_HI, P_SUM_LO, P_TAIL1, P_TAIL2
    } parse_phase_t;

    cfg_t         regs;
    parse_phase_t phase;
    int unsigned  data_idx;
    logic [15:0]  running_sum;
    logic [15:0]  sum_field;
    logic [7:0]   func_byte;
    logic [7:0]   sub_byte;
    logic [7:0]   payload [PAYLOAD_BYTES];
    logic [15:0]  speed_fb;
    logic [7:0]   status_lo;
    result_t      frames_due [$];
    int           fail_total = 0;
    int           checked_total = 0;

    // lowest set level-one bit wins, then the two level-two bits
    function automatic logic [CODE_W-1:0] fault_code_of();
        logic [15:0] lv1;
        logic [7:0]  lv2;
        lv1 = {payload[0], payload[1]};
        lv2 = payload[3];
        for (int k = 0; k < FAULT_L1_BITS; k++)
            if (lv1[k]) return CODE_W'(k + 1);
        if (lv2[0]) return FAULT_L2_B0;
        if (lv2[1]) return FAULT_L2_B1;
        return FAULT_NONE;
    endfunction

    task automatic parse_byte(input logic [7:0] b, input logic latched);
        result_t r;
        case (phase)
            P_HUNT: if (b == regs.header_first) phase = P_HDR2;
            P_HDR2: phase = (b == regs.header_second) ? P_ID : P_HUNT;
            P_ID: begin
                if (b == regs.receive_id) begin
                    running_sum = 16'(b);
                    phase = P_FUNC;
                end else begin
                    phase = P_HUNT;
                end
            end
            P_FUNC: begin
                func_byte = b;
                running_sum += 16'(b);
                phase = P_SUB;
            end
            P_SUB: begin
                sub_byte = b;
                running_sum += 16'(b);
                data_idx = 0;
                phase = P_DATA;
            end
            P_DATA: begin
                payload[data_idx] = b;
                running_sum += 16'(b);
                data_idx++;
                if (data_idx >= PAYLOAD_BYTES) phase = P_SUM_HI;
            end
            P_SUM_HI: begin
                sum_field = {b, 8'h00};
                phase = P_SUM_LO;
            end
            P_SUM_LO: begin
                sum_field[7:0] = b;
                phase = (sum_field == running_sum) ? P_TAIL1 : P_HUNT;
            end
            P_TAIL1: phase = (b == regs.tail_first) ? P_TAIL2 : P_HUNT;
            P_TAIL2: begin
                phase = P_HUNT;
                if (b == regs.tail_second) begin
                    r.func_code  = func_byte;
                    r.sub_func   = sub_byte;
                    r.fault_code = FAULT_NONE;
                    if (func_byte == FUNC_DRIVE && sub_byte == SUB_STATUS) begin
                        r.kind    = KIND_STATUS;
                        speed_fb  = {payload[0], payload[1]};
                        status_lo = payload[3];
                    end else if (func_byte == FUNC_DRIVE && sub_byte == SUB_FAULT) begin
                        r.kind = KIND_FAULT;
                        if (!latched) r.fault_code = fault_code_of();
                    end else begin
                        r.kind = KIND_OTHER;
                    end
                    r.feedback_speed = speed_fb;
                    r.lower_status   = status_lo;
                    frames_due.push_back(r);
                end
            end
            default: phase = P_HUNT;
        endcase
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            fail_total++;
        end
    endtask

    always @(posedge aclk) begin : watch
        result_t want;
        if (!aresetn) begin
            regs = '{header_first:  HEADER_FIRST_RST,  header_second: HEADER_SECOND_RST,
                     receive_id:    RECEIVE_ID_RST,    tail_first:    TAIL_FIRST_RST,
                     tail_second:   TAIL_SECOND_RST};
            phase       = P_HUNT;
            data_idx    = 0;
            running_sum = '0;
            sum_field   = '0;
            func_byte   = '0;
            sub_byte    = '0;
            speed_fb    = '0;
            status_lo   = '0;
            foreach (payload[i]) payload[i] = '0;
            frames_due.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_HEADER_FIRST:  regs.header_first  = cfg_wdata;
                    REG_HEADER_SECOND: regs.header_second = cfg_wdata;
                    REG_RECEIVE_ID:    regs.receive_id    = cfg_wdata;
                    REG_TAIL_FIRST:    regs.tail_first    = cfg_wdata;
                    REG_TAIL_SECOND:   regs.tail_second   = cfg_wdata;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (frames_due.size() == 0) begin
                    $error("result transaction with no frame pending: tdata 0x%0h", m_tdata);
                    fail_total++;
                end else begin
                    want = frames_due.pop_front();
                    check_field("frame_kind",     16'(want.kind),           16'(m_tuser));
                    check_field("func_code",      16'(want.func_code),      16'(m_tdata[7:0]));
                    check_field("sub_func",       16'(want.sub_func),       16'(m_tdata[15:8]));
                    check_field("feedback_speed", want.feedback_speed,      m_tdata[31:16]);
                    check_field("lower_status",   16'(want.lower_status),   16'(m_tdata[39:32]));
                    check_field("fault_code",     16'(want.fault_code),     16'(m_tdata[43:40]));
                    checked_total++;
                end
            end
            if (s_tvalid && s_tready) parse_byte(s_tdata[7:0], s_tdata[8]);
        end
        mismatches      <= fail_total;
        results_pending <= frames_due.size();
        results_checked <= checked_total;
    end

endmodule

>>> verif/checksummed_frame_receiver_top_tb.sv
// Testbench top of the checksummed frame receiver: clock, reset, stimulus and verdict.
module checksummed_frame_receiver_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cfr_pkg::*;

    // Ways a generated frame can be damaged on purpose
    typedef enum int {
        FLAW_NONE, FLAW_HEADER2, FLAW_ID, FLAW_SUM, FLAW_TAIL1, FLAW_TAIL2
    } flaw_t;

    localparam int PAY = PAYLOAD_BYTES_DEF;
    // index past the register list, must be ignored by the block
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    // roughly 1150 random bytes spread over four register settings
    localparam int BYTES_PER_SETTING = 290;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [BYTE_W-1:0]    cfg_wdata = '0;

    int   mismatches;
    int   results_pending;
    int   results_checked;

    // percent of cycles either side sits idle; dropped to zero for one stretch
    int   idle_pct      = 26;
    int   bytes_sent    = 0;
    int   frames_status = 0;
    int   frames_fault  = 0;
    int   frames_other  = 0;
    int   frames_flawed = 0;
    cfg_t cur_cfg;

    checksummed_frame_receiver_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    checksummed_frame_receiver_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .mismatches      (mismatches),
        .results_pending (results_pending),
        .results_checked (results_checked)
    );

    // 20 ns period
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Result side backpressure, redrawn every cycle
    always @(posedge aclk) begin
        m_tready <= aresetn && ($urandom_range(0, 99) >= idle_pct);
    end

    // Hard stop; the slowest correct run needs well under a tenth of this
    initial begin
        #2_000_000;
        $display("timeout: %0d results still pending", results_pending);
        $display("checksummed_frame_receiver_top: mismatch");
        $finish;
    end

    // One input transaction. An idle gap is inserted only by lowering tvalid at the
    // step after the previous handshake, so tvalid never gets two updates per step.
    // Each idle cycle is drawn on its own, so gaps stay near idle_pct of all cycles.
    task automatic push_byte(input logic [7:0] b, input logic latched);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, latched, b};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_sent++;
    endtask

    // Stop sending and let every pending result drain, plus the block's input and output
    // registers with margin, so register writes hit an idle block.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Writes all five registers back to back, then one write past the list.
    task automatic load_settings(input cfg_t c);
        cfg_we    <= 1'b1;
        cfg_index <= REG_HEADER_FIRST;
        cfg_wdata <= c.header_first;
        @(posedge aclk);
        cfg_index <= REG_HEADER_SECOND;
        cfg_wdata <= c.header_second;
        @(posedge aclk);
        cfg_index <= REG_RECEIVE_ID;
        cfg_wdata <= c.receive_id;
        @(posedge aclk);
        cfg_index <= REG_TAIL_FIRST;
        cfg_wdata <= c.tail_first;
        @(posedge aclk);
        cfg_index <= REG_TAIL_SECOND;
        cfg_wdata <= c.tail_second;
        @(posedge aclk);
        cfg_index <= REG_UNUSED;
        cfg_wdata <= 8'($urandom);
        @(posedge aclk);
        cfg_we    <= 1'b0;
        cur_cfg = c;
    endtask

    // Payload bytes, data0 in the low byte. Fault payloads are shaped so every
    // fault code turns up: a lowest set level-one bit, only level-two bits, or none.
    function automatic logic [8*PAY-1:0] make_payload(input kind_t k);
        logic [8*PAY-1:0] d;
        logic [15:0]      lv1;
        int               pick;
        pick = $urandom_range(0, 15);
        for (int i = 0; i < PAY; i++) d[8*i +: 8] = 8'($urandom);
        if (k == KIND_FAULT) begin
            if (pick < FAULT_L1_BITS) begin
                lv1 = 16'($urandom) << pick;
                lv1[pick] = 1'b1;
            end else begin
                lv1 = {3'($urandom), 13'd0};
                if (pick == FAULT_L1_BITS) begin
                    d[24] = 1'b1;
                end else if (pick == FAULT_L1_BITS + 1) begin
                    d[25:24] = 2'b10;
                end else begin
                    d[25:24] = 2'b00;    // no fault bit anywhere
                end
            end
            d[7:0]  = lv1[15:8];
            d[15:8] = lv1[7:0];
        end else if (pick == 0) begin
            d = '0;
        end else if (pick == 1) begin
            d = '1;
        end
        return d;
    endfunction

    // Builds one frame under the current settings; a flaw damages one byte.
    task automatic send_frame(input logic [7:0] func, input logic [7:0] sub,
                              input logic [8*PAY-1:0] data, input logic latched,
                              input flaw_t flaw);
        logic [7:0]  frame [PAY+9];
        logic [15:0] sum;
        logic [7:0]  spoil;
        spoil = 8'($urandom_range(1, 255));
        sum = 16'(cur_cfg.receive_id) + 16'(func) + 16'(sub);
        frame[0] = cur_cfg.header_first;
        frame[1] = cur_cfg.header_second;
        frame[2] = cur_cfg.receive_id;
        frame[3] = func;
        frame[4] = sub;
        for (int i = 0; i < PAY; i++) begin
            frame[5+i] = data[8*i +: 8];
            sum += 16'(data[8*i +: 8]);
        end
        frame[PAY+5] = sum[15:8];
        frame[PAY+6] = sum[7:0];
        frame[PAY+7] = cur_cfg.tail_first;
        frame[PAY+8] = cur_cfg.tail_second;
        case (flaw)
            FLAW_HEADER2: frame[1] ^= spoil;
            FLAW_ID:      frame[2] ^= spoil;
            FLAW_SUM:     frame[PAY + 5 + $urandom_range(0, 1)] ^= spoil;
            FLAW_TAIL1:   frame[PAY+7] ^= spoil;
            FLAW_TAIL2:   frame[PAY+8] ^= spoil;
            default: ;
        endcase
        // fault_latched only counts on the closing byte; random everywhere else
        for (int i = 0; i < PAY + 9; i++)
            push_byte(frame[i], (i == PAY + 8) ? latched : 1'($urandom_range(0, 1)));
    endtask

    // Mostly good frames with random content, some damaged ones, some line noise.
    task automatic random_traffic(input int quota);
        int         stop_at;
        int         pick;
        int         sel;
        kind_t      k;
        logic [7:0] func;
        logic [7:0] sub;
        logic       latched;
        stop_at = bytes_sent + quota;
        while (bytes_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 84) begin
                sel = $urandom_range(0, 9);
                if (sel < 3) begin
                    k = KIND_STATUS;
                    func = FUNC_DRIVE;
                    sub = SUB_STATUS;
                end else if (sel < 7) begin
                    k = KIND_FAULT;
                    func = FUNC_DRIVE;
                    sub = SUB_FAULT;
                end else begin
                    // near misses on the drive function are the interesting ones
                    k = KIND_OTHER;
                    func = ($urandom_range(0, 2) == 0) ? FUNC_DRIVE : 8'($urandom);
                    sub = ($urandom_range(0, 2) == 0) ? SUB_FAULT : 8'($urandom);
                    if (func == FUNC_DRIVE && (sub == SUB_STATUS || sub == SUB_FAULT))
                        sub = 8'($urandom_range(2, 255));
                end
                latched = ($urandom_range(0, 99) < 30);
                if (pick < 70) begin
                    send_frame(func, sub, make_payload(k), latched, FLAW_NONE);
                    case (k)
                        KIND_STATUS: frames_status++;
                        KIND_FAULT:  frames_fault++;
                        default:     frames_other++;
                    endcase
                end else begin
                    send_frame(func, sub, make_payload(k), latched,
                               flaw_t'($urandom_range(FLAW_HEADER2, FLAW_TAIL2)));
                    frames_flawed++;
                end
            end else begin
                repeat ($urandom_range(1, 6))
                    push_byte(($urandom_range(0, 3) == 0) ? cur_cfg.header_first
                                                          : 8'($urandom),
                              1'($urandom_range(0, 1)));
            end
        end
    endtask

    initial begin
        cfg_t all_low;
        cfg_t all_high;
        cfg_t mixed;
        all_low  = '0;
        all_high = '1;
        mixed    = cfg_t'({$urandom, 8'($urandom)});
        cur_cfg  = '{header_first:  HEADER_FIRST_RST,  header_second: HEADER_SECOND_RST,
                     receive_id:    RECEIVE_ID_RST,    tail_first:    TAIL_FIRST_RST,
                     tail_second:   TAIL_SECOND_RST};

        // Single synchronous reset at the start of the run
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: status frame with saturated payload while a fault is latched,
        // then a header start followed by a repeated first header byte. That second
        // byte fails the second-header check and is dropped, not taken as a new start.
        send_frame(FUNC_DRIVE, SUB_STATUS, '1, 1'b1, FLAW_NONE);
        frames_status++;
        push_byte(cur_cfg.header_first, 1'b0);
        push_byte(cur_cfg.header_first, 1'b1);
        push_byte(cur_cfg.header_second, 1'b0);
        push_byte(8'h00, 1'b0);

        // Reset register values
        random_traffic(BYTES_PER_SETTING);

        // Every register at zero
        drain_results();
        load_settings(all_low);
        random_traffic(BYTES_PER_SETTING);

        // Every register at 0xFF, and a stretch where neither side idles
        drain_results();
        load_settings(all_high);
        idle_pct = 0;
        random_traffic(BYTES_PER_SETTING);
        idle_pct = 26;

        // Random register values
        drain_results();
        load_settings(mixed);
        random_traffic(BYTES_PER_SETTING);

        drain_results();

        $display("covered %0d input bytes: %0d status, %0d fault, %0d other and %0d damaged frames",
                 bytes_sent, frames_status, frames_fault, frames_other, frames_flawed);
        $display("%0d results compared over reset, all-zero, all-ones and random registers",
                 results_checked);
        if (mismatches == 0 && results_pending == 0) begin
            $display("checksummed_frame_receiver_top: match");
        end else begin
            $display("checksummed_frame_receiver_top: mismatch");
        end
        $finish;
    end

endmodule

>>> sim.f
sv/cfr_pkg.sv
sv/cfr_fault_enc.sv
sv/cfr_parser.sv
sv/checksummed_frame_receiver_top.sv
verif/checksummed_frame_receiver_checker.sv
verif/checksummed_frame_receiver_top_tb.sv
